@@ sv/dpw_pkg.sv @@
`default_nettype none

package dpw_pkg;

    localparam int unsigned PERIOD_BITS       = 16;
    localparam int unsigned COUNT_BITS        = PERIOD_BITS + 1;
    localparam int unsigned TIMEOUT_BITS      = 8;
    localparam int unsigned DELAY_BITS        = 3;
    localparam int unsigned WAKE_MAX_TIMEOUTS = 3;
    localparam int unsigned SHUT_MAX_TIMEOUTS = 3;
    localparam int unsigned RESTART_LIMIT     = 3;

    localparam logic       KIND_TICK    = 1'b0;
    localparam logic       KIND_CMD     = 1'b1;
    localparam logic [7:0] TARGET_WAKE  = 8'h01;
    localparam logic [7:0] TARGET_SHUT  = 8'h02;
    localparam logic [7:0] FLAG_ENABLE  = 8'h01;
    localparam logic [7:0] FLAG_DISABLE = 8'h02;

    localparam logic [2:0] PS_S0 = 3'd0;
    localparam logic [2:0] PS_S3 = 3'd1;
    localparam logic [2:0] PS_S5 = 3'd2;
    localparam logic [2:0] PS_G3 = 3'd3;

    typedef struct packed {
        logic                   kind;
        logic [7:0]             cmd_target;
        logic [7:0]             cmd_flag;
        logic [PERIOD_BITS-1:0] cmd_period;
        logic [2:0]             power_state;
    } item_t;

    typedef struct packed {
        logic                    force_off;
        logic                    power_on_pulse;
        logic                    record_write;
        logic [TIMEOUT_BITS-1:0] record_value;
        logic                    active;
    } wake_res_t;

    typedef struct packed {
        logic fire;
        logic active;
    } shut_res_t;

    function automatic logic [TIMEOUT_BITS-1:0] sat_inc(input logic [TIMEOUT_BITS-1:0] v);
        return (v == {TIMEOUT_BITS{1'b1}}) ? v : v + TIMEOUT_BITS'(1);
    endfunction

    function automatic logic apply_flag(input logic en, input logic [7:0] flag);
        logic r;
        r = en;
        if (flag == FLAG_ENABLE)
        begin
            r = 1'b1;
        end
        else if (flag == FLAG_DISABLE)
        begin
            r = 1'b0;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ sv/dual_power_watchdog.sv @@
// Channel  Handshake                     Payload
// item     item_valid / item_ready       kind, cmd_target, cmd_flag, cmd_period, power_state
// result   result_valid / result_ready   wakeup_force_off, shutdown_fire, power_on_pulse,
//                                        record_write, record_value, wakeup_active,
//                                        shutdown_active
//
// One request per cycle is accepted while the input register is empty or can advance;
// each result is registered in the input register and then in the result register,
// around the combinational watchdog update.
// Reset clears both watchdogs and the restart delay; no clearing pass is needed.
// A stalled result holds the result register, and the input register keeps taking
// one more request until it too is full.
`default_nettype none

module dual_power_watchdog (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             item_valid,
    output logic                                  item_ready,
    input  wire logic                             kind,
    input  wire logic [7:0]                       cmd_target,
    input  wire logic [7:0]                       cmd_flag,
    input  wire logic [dpw_pkg::PERIOD_BITS-1:0]  cmd_period,
    input  wire logic [2:0]                       power_state,
    output logic                                  result_valid,
    input  wire logic                             result_ready,
    output logic                                  wakeup_force_off,
    output logic                                  shutdown_fire,
    output logic                                  power_on_pulse,
    output logic                                  record_write,
    output logic [dpw_pkg::TIMEOUT_BITS-1:0]      record_value,
    output logic                                  wakeup_active,
    output logic                                  shutdown_active
);

    logic                  in_valid_reg;
    dpw_pkg::item_t        in_item_reg;
    logic                  out_valid_reg;
    dpw_pkg::wake_res_t    wake_res_reg;
    dpw_pkg::shut_res_t    shut_res_reg;

    dpw_pkg::wake_res_t    wake_res;
    dpw_pkg::shut_res_t    shut_res;
    logic                  advance;
    logic                  accept;

    assign advance    = in_valid_reg && (!out_valid_reg || result_ready);
    assign item_ready = !in_valid_reg || advance;
    assign accept     = item_valid && item_ready;

    dpw_wake_unit u_wake (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (in_item_reg),
        .res     (wake_res)
    );

    dpw_shut_unit u_shut (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (in_item_reg),
        .res     (shut_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_item_reg.kind        <= kind;
            in_item_reg.cmd_target  <= cmd_target;
            in_item_reg.cmd_flag    <= cmd_flag;
            in_item_reg.cmd_period  <= cmd_period;
            in_item_reg.power_state <= power_state;
        end
        if (advance)
        begin
            wake_res_reg <= wake_res;
            shut_res_reg <= shut_res;
        end
    end

    assign result_valid     = out_valid_reg;
    assign wakeup_force_off = wake_res_reg.force_off;
    assign shutdown_fire    = shut_res_reg.fire;
    assign power_on_pulse   = wake_res_reg.power_on_pulse;
    assign record_write     = wake_res_reg.record_write;
    assign record_value     = wake_res_reg.record_value;
    assign wakeup_active    = wake_res_reg.active;
    assign shutdown_active  = shut_res_reg.active;

endmodule

`default_nettype wire

@@ sv/dpw_wake_unit.sv @@
`default_nettype none

module dpw_wake_unit (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              advance,
    input  wire dpw_pkg::item_t    item,
    output dpw_pkg::wake_res_t     res
);

    logic                                en_reg, en_next;
    logic [dpw_pkg::PERIOD_BITS-1:0]     period_reg, period_next;
    logic [dpw_pkg::COUNT_BITS-1:0]      count_reg, count_next;
    logic [dpw_pkg::TIMEOUT_BITS-1:0]    timeouts_reg, timeouts_next;
    logic [dpw_pkg::DELAY_BITS-1:0]      delay_reg, delay_next;

    logic [dpw_pkg::COUNT_BITS-1:0]      count_inc;
    logic [dpw_pkg::DELAY_BITS-1:0]      delay_inc;
    logic                                expire;
    logic                                off_state;

    always_comb
    begin
        en_next       = en_reg;
        period_next   = period_reg;
        count_next    = count_reg;
        timeouts_next = timeouts_reg;
        delay_next    = delay_reg;
        res           = '0;

        count_inc = count_reg + dpw_pkg::COUNT_BITS'(1);
        expire    = count_inc > {1'b0, period_reg};
        off_state = (item.power_state == dpw_pkg::PS_S5) || (item.power_state == dpw_pkg::PS_G3);
        delay_inc = '0;

        if (item.kind == dpw_pkg::KIND_CMD)
        begin
            if (item.cmd_target == dpw_pkg::TARGET_WAKE)
            begin
                en_next     = dpw_pkg::apply_flag(en_reg, item.cmd_flag);
                period_next = item.cmd_period;
            end
        end
        else if (en_reg)
        begin
            count_next = count_inc;
            if (expire)
            begin
                count_next    = '0;
                timeouts_next = dpw_pkg::sat_inc(timeouts_reg);
                if (item.power_state == dpw_pkg::PS_S0)
                begin
                    res.force_off = 1'b1;
                    delay_next    = dpw_pkg::DELAY_BITS'(1);
                end
            end
            if (timeouts_next > dpw_pkg::TIMEOUT_BITS'(dpw_pkg::WAKE_MAX_TIMEOUTS))
            begin
                en_next    = 1'b0;
                count_next = '0;
            end
            // The restart delay only runs once the board has actually gone down.
            delay_inc = delay_next + dpw_pkg::DELAY_BITS'(1);
            if (off_state && (delay_next != '0))
            begin
                delay_next = delay_inc;
                if (delay_inc > dpw_pkg::DELAY_BITS'(dpw_pkg::RESTART_LIMIT))
                begin
                    res.power_on_pulse = 1'b1;
                    res.record_write   = 1'b1;
                    res.record_value   = timeouts_next;
                    delay_next         = '0;
                end
            end
        end
        res.active = en_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            en_reg       <= 1'b0;
            period_reg   <= '0;
            count_reg    <= '0;
            timeouts_reg <= '0;
            delay_reg    <= '0;
        end
        else if (advance)
        begin
            en_reg       <= en_next;
            period_reg   <= period_next;
            count_reg    <= count_next;
            timeouts_reg <= timeouts_next;
            delay_reg    <= delay_next;
        end
    end

endmodule

`default_nettype wire

@@ sv/dpw_shut_unit.sv @@
`default_nettype none

module dpw_shut_unit (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              advance,
    input  wire dpw_pkg::item_t    item,
    output dpw_pkg::shut_res_t     res
);

    logic                                en_reg, en_next;
    logic [dpw_pkg::PERIOD_BITS-1:0]     period_reg, period_next;
    logic [dpw_pkg::COUNT_BITS-1:0]      count_reg, count_next;
    logic [dpw_pkg::TIMEOUT_BITS-1:0]    timeouts_reg, timeouts_next;

    logic [dpw_pkg::COUNT_BITS-1:0]      count_inc;
    logic                                expire;

    always_comb
    begin
        en_next       = en_reg;
        period_next   = period_reg;
        count_next    = count_reg;
        timeouts_next = timeouts_reg;
        res           = '0;

        count_inc = count_reg + dpw_pkg::COUNT_BITS'(1);
        expire    = count_inc > {1'b0, period_reg};

        if (item.kind == dpw_pkg::KIND_CMD)
        begin
            if (item.cmd_target == dpw_pkg::TARGET_SHUT)
            begin
                en_next     = dpw_pkg::apply_flag(en_reg, item.cmd_flag);
                period_next = item.cmd_period;
            end
        end
        else if (en_reg)
        begin
            count_next = count_inc;
            if (expire)
            begin
                count_next    = '0;
                timeouts_next = dpw_pkg::sat_inc(timeouts_reg);
                if (item.power_state == dpw_pkg::PS_S0)
                begin
                    res.fire = 1'b1;
                end
            end
            if (timeouts_next > dpw_pkg::TIMEOUT_BITS'(dpw_pkg::SHUT_MAX_TIMEOUTS))
            begin
                en_next    = 1'b0;
                count_next = '0;
            end
            // A tick in S3 or S5 while enabled makes the watchdog forget its setup entirely.
            if ((item.power_state == dpw_pkg::PS_S5) || (item.power_state == dpw_pkg::PS_S3))
            begin
                en_next       = 1'b0;
                timeouts_next = '0;
                count_next    = '0;
                period_next   = '0;
            end
        end
        res.active = en_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            en_reg       <= 1'b0;
            period_reg   <= '0;
            count_reg    <= '0;
            timeouts_reg <= '0;
        end
        else if (advance)
        begin
            en_reg       <= en_next;
            period_reg   <= period_next;
            count_reg    <= count_next;
            timeouts_reg <= timeouts_next;
        end
    end

endmodule

`default_nettype wire

@@ dv/dual_power_watchdog_tb.sv @@
module dual_power_watchdog_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [7:0] TARGET_NONE  = 8'h00;
    localparam logic [7:0] TARGET_ALL   = 8'hFF;
    localparam logic [7:0] FLAG_NONE    = 8'h00;
    localparam logic [7:0] FLAG_KEEP    = 8'hFF;
    localparam logic [7:0] FLAG_ODD     = 8'hFE;
    localparam logic [2:0] PS_OTHER     = 3'd4;
    localparam logic [2:0] PS_TOP       = 3'd7;
    localparam logic [dpw_pkg::PERIOD_BITS-1:0] PERIOD_MAX = {dpw_pkg::PERIOD_BITS{1'b1}};
    localparam logic [dpw_pkg::TIMEOUT_BITS-1:0] TIMEOUT_CEIL = {dpw_pkg::TIMEOUT_BITS{1'b1}};
    localparam int RANDOM_PER_PHASE = 385;
    localparam int MISMATCH_SHOWN   = 10;

    typedef struct packed {
        logic                             force_off;
        logic                             fire;
        logic                             pulse;
        logic                             rec;
        logic [dpw_pkg::TIMEOUT_BITS-1:0] rec_val;
        logic                             wake_on;
        logic                             shut_on;
    } wd_outcome_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    dpw_pkg::item_t req_bus = '0;
    logic  item_valid = 1'b0;
    logic  item_ready;
    logic  result_valid;
    logic  result_ready = 1'b0;

    logic                             wakeup_force_off;
    logic                             shutdown_fire;
    logic                             power_on_pulse;
    logic                             record_write;
    logic [dpw_pkg::TIMEOUT_BITS-1:0] record_value;
    logic                             wakeup_active;
    logic                             shutdown_active;

    dpw_pkg::item_t pending_requests[$];
    wd_outcome_t    predicted_actions[$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int fail_count     = 0;
    int request_total  = 0;
    int queued_count   = 0;
    int n_force_off    = 0;
    int n_fire         = 0;
    int n_pulse        = 0;

    // Watchdog state as the testbench predicts it.
    logic                             wd_wake_on;
    logic [dpw_pkg::PERIOD_BITS-1:0]  wd_wake_period;
    logic [dpw_pkg::COUNT_BITS-1:0]   wd_wake_count;
    logic [dpw_pkg::TIMEOUT_BITS-1:0] wd_wake_timeouts;
    logic [dpw_pkg::DELAY_BITS-1:0]   wd_restart_delay;
    logic                             wd_shut_on;
    logic [dpw_pkg::PERIOD_BITS-1:0]  wd_shut_period;
    logic [dpw_pkg::COUNT_BITS-1:0]   wd_shut_count;
    logic [dpw_pkg::TIMEOUT_BITS-1:0] wd_shut_timeouts;

    dual_power_watchdog u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .item_valid       (item_valid),
        .item_ready       (item_ready),
        .kind             (req_bus.kind),
        .cmd_target       (req_bus.cmd_target),
        .cmd_flag         (req_bus.cmd_flag),
        .cmd_period       (req_bus.cmd_period),
        .power_state      (req_bus.power_state),
        .result_valid     (result_valid),
        .result_ready     (result_ready),
        .wakeup_force_off (wakeup_force_off),
        .shutdown_fire    (shutdown_fire),
        .power_on_pulse   (power_on_pulse),
        .record_write     (record_write),
        .record_value     (record_value),
        .wakeup_active    (wakeup_active),
        .shutdown_active  (shutdown_active)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    task automatic clear_watchdogs();
        wd_wake_on       = 1'b0;
        wd_wake_period   = '0;
        wd_wake_count    = '0;
        wd_wake_timeouts = '0;
        wd_restart_delay = '0;
        wd_shut_on       = 1'b0;
        wd_shut_period   = '0;
        wd_shut_count    = '0;
        wd_shut_timeouts = '0;
    endtask

    task automatic step_watchdogs(input dpw_pkg::item_t rq);
        wd_outcome_t o;
        o = '0;
        if (rq.kind == dpw_pkg::KIND_CMD)
        begin
            if (rq.cmd_target == dpw_pkg::TARGET_WAKE)
            begin
                if (rq.cmd_flag == dpw_pkg::FLAG_ENABLE)
                    wd_wake_on = 1'b1;
                else if (rq.cmd_flag == dpw_pkg::FLAG_DISABLE)
                    wd_wake_on = 1'b0;
                wd_wake_period = rq.cmd_period;
            end
            else if (rq.cmd_target == dpw_pkg::TARGET_SHUT)
            begin
                if (rq.cmd_flag == dpw_pkg::FLAG_ENABLE)
                    wd_shut_on = 1'b1;
                else if (rq.cmd_flag == dpw_pkg::FLAG_DISABLE)
                    wd_shut_on = 1'b0;
                wd_shut_period = rq.cmd_period;
            end
        end
        else
        begin
            if (wd_wake_on)
            begin
                wd_wake_count = wd_wake_count + 1'b1;
                if (wd_wake_count > {1'b0, wd_wake_period})
                begin
                    wd_wake_count = '0;
                    if (wd_wake_timeouts != TIMEOUT_CEIL)
                        wd_wake_timeouts = wd_wake_timeouts + 1'b1;
                    if (rq.power_state == dpw_pkg::PS_S0)
                    begin
                        o.force_off      = 1'b1;
                        wd_restart_delay = dpw_pkg::DELAY_BITS'(1);
                    end
                end
                if (wd_wake_timeouts > dpw_pkg::WAKE_MAX_TIMEOUTS)
                begin
                    wd_wake_on    = 1'b0;
                    wd_wake_count = '0;
                end
                // The restart delay only moves on while the system is fully off.
                if ((rq.power_state == dpw_pkg::PS_S5 || rq.power_state == dpw_pkg::PS_G3) &&
                    wd_restart_delay != '0)
                begin
                    wd_restart_delay = wd_restart_delay + 1'b1;
                    if (wd_restart_delay > dpw_pkg::RESTART_LIMIT)
                    begin
                        o.pulse          = 1'b1;
                        o.rec            = 1'b1;
                        o.rec_val        = wd_wake_timeouts;
                        wd_restart_delay = '0;
                    end
                end
            end
            if (wd_shut_on)
            begin
                wd_shut_count = wd_shut_count + 1'b1;
                if (wd_shut_count > {1'b0, wd_shut_period})
                begin
                    wd_shut_count = '0;
                    if (wd_shut_timeouts != TIMEOUT_CEIL)
                        wd_shut_timeouts = wd_shut_timeouts + 1'b1;
                    if (rq.power_state == dpw_pkg::PS_S0)
                        o.fire = 1'b1;
                end
                if (wd_shut_timeouts > dpw_pkg::SHUT_MAX_TIMEOUTS)
                begin
                    wd_shut_on    = 1'b0;
                    wd_shut_count = '0;
                end
                if (rq.power_state == dpw_pkg::PS_S5 || rq.power_state == dpw_pkg::PS_S3)
                begin
                    wd_shut_on       = 1'b0;
                    wd_shut_timeouts = '0;
                    wd_shut_count    = '0;
                    wd_shut_period   = '0;
                end
            end
        end
        o.wake_on = wd_wake_on;
        o.shut_on = wd_shut_on;
        predicted_actions.push_back(o);
    endtask

    // Driver: the front of the pending queue is the request on the bus.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            req_bus    <= '0;
            clear_watchdogs();
        end
        else
        begin
            logic taken;
            taken = item_valid && item_ready;
            if (taken)
            begin
                step_watchdogs(req_bus);
                void'(pending_requests.pop_front());
                request_total++;
            end
            if (item_valid && !taken)
            begin
                // Hold the request steady until it is accepted.
            end
            else if (pending_requests.size() != 0 &&
                     $urandom_range(99) >= send_idle_pct)
            begin
                item_valid <= 1'b1;
                req_bus    <= pending_requests[0];
            end
            else
            begin
                item_valid <= 1'b0;
            end
        end
    end

    // Monitor: every accepted result is checked against the oldest prediction.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_ready <= 1'b0;
        end
        else
        begin
            wd_outcome_t got;
            wd_outcome_t want;
            if (result_valid && result_ready)
            begin
                got.force_off = wakeup_force_off;
                got.fire      = shutdown_fire;
                got.pulse     = power_on_pulse;
                got.rec       = record_write;
                got.rec_val   = record_value;
                got.wake_on   = wakeup_active;
                got.shut_on   = shutdown_active;
                n_force_off  += got.force_off;
                n_fire       += got.fire;
                n_pulse      += got.pulse;
                if (predicted_actions.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= MISMATCH_SHOWN)
                        $display("unexpected result at %0t: %p", $realtime, got);
                end
                else
                begin
                    want = predicted_actions.pop_front();
                    if (got !== want)
                    begin
                        fail_count++;
                        if (fail_count <= MISMATCH_SHOWN)
                            $display("mismatch at %0t: expected %p, got %p",
                                     $realtime, want, got);
                    end
                end
            end
            result_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic push_cmd(input logic [7:0] target, input logic [7:0] flag,
                            input logic [dpw_pkg::PERIOD_BITS-1:0] period);
        dpw_pkg::item_t rq;
        rq.kind        = dpw_pkg::KIND_CMD;
        rq.cmd_target  = target;
        rq.cmd_flag    = flag;
        rq.cmd_period  = period;
        rq.power_state = 3'($urandom_range(0, 7));
        pending_requests.push_back(rq);
        queued_count++;
    endtask

    task automatic push_tick(input logic [2:0] ps);
        dpw_pkg::item_t rq;
        rq.kind        = dpw_pkg::KIND_TICK;
        rq.cmd_target  = 8'($urandom);
        rq.cmd_flag    = 8'($urandom);
        rq.cmd_period  = dpw_pkg::PERIOD_BITS'($urandom);
        rq.power_state = ps;
        pending_requests.push_back(rq);
        queued_count++;
    endtask

    function automatic logic [2:0] off_state();
        return $urandom_range(0, 1) ? dpw_pkg::PS_S5 : dpw_pkg::PS_G3;
    endfunction

    // Mostly wake expiry-and-restart or shutdown expiry sequences, the rest single commands and loose requests.
    task automatic queue_scenario();
        int pick;
        int n;
        dpw_pkg::item_t rq;
        pick = $urandom_range(99);
        if (pick < 35)
        begin
            push_cmd(dpw_pkg::TARGET_WAKE, dpw_pkg::FLAG_ENABLE,
                     dpw_pkg::PERIOD_BITS'($urandom_range(0, 3)));
            n = $urandom_range(1, 5);
            repeat (n) push_tick($urandom_range(0, 5) == 0 ? PS_OTHER : dpw_pkg::PS_S0);
            if ($urandom_range(0, 1))
                push_cmd(dpw_pkg::TARGET_WAKE,
                         $urandom_range(0, 1) ? dpw_pkg::FLAG_ENABLE : FLAG_KEEP,
                         dpw_pkg::PERIOD_BITS'($urandom_range(4, 20)));
            n = $urandom_range(2, 5);
            repeat (n) push_tick(off_state());
        end
        else if (pick < 60)
        begin
            push_cmd(dpw_pkg::TARGET_SHUT, dpw_pkg::FLAG_ENABLE,
                     dpw_pkg::PERIOD_BITS'($urandom_range(0, 3)));
            n = $urandom_range(1, 6);
            repeat (n) push_tick(dpw_pkg::PS_S0);
            push_tick(3'($urandom_range(0, 7)));
        end
        else if (pick < 70)
        begin
            push_cmd($urandom_range(0, 1) ? dpw_pkg::TARGET_WAKE : dpw_pkg::TARGET_SHUT,
                     $urandom_range(0, 1) ? dpw_pkg::FLAG_DISABLE : 8'($urandom),
                     dpw_pkg::PERIOD_BITS'($urandom));
        end
        else
        begin
            rq.kind        = 1'($urandom_range(0, 1));
            rq.cmd_target  = $urandom_range(0, 1) ? 8'($urandom_range(1, 2)) : 8'($urandom);
            rq.cmd_flag    = $urandom_range(0, 1) ? 8'($urandom_range(0, 3)) : 8'($urandom);
            rq.cmd_period  = $urandom_range(0, 1)
                             ? dpw_pkg::PERIOD_BITS'($urandom_range(0, 7))
                             : dpw_pkg::PERIOD_BITS'($urandom);
            rq.power_state = 3'($urandom_range(0, 7));
            pending_requests.push_back(rq);
            queued_count++;
        end
    endtask

    task automatic wait_drained();
        while (pending_requests.size() != 0 || item_valid || predicted_actions.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int idle_send[4];
        int idle_recv[4];
        idle_send = '{0, 88, 0, 28};
        idle_recv = '{0, 0, 88, 28};

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed requests: ignored targets, zero and full periods, restart pulse,
        // shutdown clear in S3 and S5, self-disable, unknown power states.
        push_tick(PS_TOP);
        push_cmd(TARGET_NONE, dpw_pkg::FLAG_ENABLE, PERIOD_MAX);
        push_cmd(TARGET_ALL, FLAG_KEEP, '0);
        push_cmd(dpw_pkg::TARGET_WAKE, dpw_pkg::FLAG_ENABLE, '0);
        push_tick(dpw_pkg::PS_S0);
        push_cmd(dpw_pkg::TARGET_WAKE, FLAG_KEEP, PERIOD_MAX);
        push_tick(dpw_pkg::PS_S5);
        push_tick(dpw_pkg::PS_G3);
        push_tick(dpw_pkg::PS_S5);
        push_tick(PS_OTHER);
        push_cmd(dpw_pkg::TARGET_SHUT, dpw_pkg::FLAG_ENABLE, '0);
        push_tick(dpw_pkg::PS_S0);
        push_tick(dpw_pkg::PS_S3);
        push_cmd(dpw_pkg::TARGET_SHUT, dpw_pkg::FLAG_ENABLE, dpw_pkg::PERIOD_BITS'(1));
        push_tick(dpw_pkg::PS_S0);
        push_tick(dpw_pkg::PS_S0);
        push_tick(dpw_pkg::PS_S5);
        push_cmd(dpw_pkg::TARGET_WAKE, dpw_pkg::FLAG_DISABLE, '0);
        push_tick(dpw_pkg::PS_S0);
        push_cmd(dpw_pkg::TARGET_WAKE, FLAG_NONE, '0);
        push_cmd(dpw_pkg::TARGET_WAKE, dpw_pkg::FLAG_ENABLE, '0);
        repeat (3) push_tick(dpw_pkg::PS_S0);
        push_cmd(dpw_pkg::TARGET_SHUT, FLAG_ODD, PERIOD_MAX);
        wait_drained();

        for (int ph = 0; ph < 4; ph++)
        begin
            @(negedge clk);
            send_idle_pct  = idle_send[ph];
            recv_stall_pct = idle_recv[ph];
            queued_count   = 0;
            while (queued_count < RANDOM_PER_PHASE)
                queue_scenario();
            // The sender holds off here until every result of the phase is back.
            wait_drained();
        end

        @(negedge clk);
        recv_stall_pct = 0;
        repeat (8) @(posedge clk);
        fail_count += predicted_actions.size();

        $display("Sent %0d requests across four idling patterns with no idle, sender idle,",
                 request_total);
        $display("receiver stall and mixed; saw %0d force-offs, %0d shutdowns, %0d restarts.",
                 n_force_off, n_fire, n_pulse);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

@@ filelist.f @@
sv/dpw_pkg.sv
sv/dpw_wake_unit.sv
sv/dpw_shut_unit.sv
sv/dual_power_watchdog.sv
dv/dual_power_watchdog_tb.sv
